// ===== sv/lpal_pkg.sv =====
// ----------------------------------------------------------------------------
// LPAL package
// Shared constants, codes and types of the table-driven phase oscillator.
// ----------------------------------------------------------------------------
package lpal_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int MAX_FRAC_BITS = 16;
  localparam int PHASE_W       = 24;
  localparam int INC_W         = 32;
  localparam int SIZE_W        = 9;
  localparam int FB_W          = 5;
  localparam int MOD_W         = 25;
  localparam int DVD_W         = 33;
  localparam int PADDR_W       = 5;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_PHASE = 2'd2;

  localparam logic [2:0] REG_TABLE_SIZE  = 3'd0;
  localparam logic [2:0] REG_FRAC_BITS   = 3'd1;
  localparam logic [2:0] REG_FREQUENCY   = 3'd2;
  localparam logic [2:0] REG_RATE_HZ     = 3'd3;
  localparam logic [2:0] REG_FREQ_SHIFT  = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [FB_W-1:0]   fb;
    logic [23:0]       freq;
    logic [15:0]       rate;
    logic [4:0]        shift;
    logic [MOD_W-1:0]  modulus;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [MOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [MOD_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] idx;
    logic [ADDR_W-1:0] nxt;
    logic [15:0]       frac;
    logic [FB_W-1:0]   fb;
  } interp_req_t;

endpackage

// ===== sv/lpal_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// LPAL configuration registers
// APB register file with clamped effective values and the phase modulus.
// ----------------------------------------------------------------------------
module lpal_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpal_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output lpal_pkg::cfg_t              cfg,
  output logic                        cfg_wr
);
  import lpal_pkg::*;

  logic [SIZE_W-1:0] table_size;
  logic [FB_W-1:0]   frac_bits;
  logic [23:0]       frequency;
  logic [15:0]       rate_hz;
  logic [4:0]        freq_shift;
  logic [2:0]        reg_idx;
  logic              wr;

  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= SIZE_W'(256);
      frac_bits   <= FB_W'(8);
      frequency   <= '0;
      rate_hz     <= 16'd44100;
      freq_shift  <= '0;
      cfg_wr      <= 1'b0;
    end else begin
      cfg_wr <= 1'b0;
      if (wr) begin
        case (reg_idx)
          REG_TABLE_SIZE: begin
            table_size <= pwdata[SIZE_W-1:0];
            cfg_wr     <= 1'b1;
          end
          REG_FRAC_BITS: begin
            frac_bits <= pwdata[FB_W-1:0];
            cfg_wr    <= 1'b1;
          end
          REG_FREQUENCY: begin
            frequency <= pwdata[23:0];
            cfg_wr    <= 1'b1;
          end
          REG_RATE_HZ: begin
            rate_hz <= pwdata[15:0];
            cfg_wr  <= 1'b1;
          end
          REG_FREQ_SHIFT: begin
            freq_shift <= pwdata[4:0];
            cfg_wr     <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TABLE_SIZE:  prdata = 32'(table_size);
      REG_FRAC_BITS:   prdata = 32'(frac_bits);
      REG_FREQUENCY:   prdata = 32'(frequency);
      REG_RATE_HZ:     prdata = 32'(rate_hz);
      REG_FREQ_SHIFT:  prdata = 32'(freq_shift);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (table_size == '0) begin
      cfg.size = SIZE_W'(1);
    end else if (table_size > SIZE_W'(TABLE_DEPTH)) begin
      cfg.size = SIZE_W'(TABLE_DEPTH);
    end else begin
      cfg.size = table_size;
    end
    cfg.fb      = (frac_bits > FB_W'(MAX_FRAC_BITS)) ? FB_W'(MAX_FRAC_BITS) : frac_bits;
    cfg.freq    = frequency;
    cfg.rate    = (rate_hz == '0) ? 16'd1 : rate_hz;
    cfg.shift   = freq_shift;
    cfg.modulus = MOD_W'(cfg.size) << cfg.fb;
  end

endmodule

// ===== sv/lpal_divider.sv =====
// ----------------------------------------------------------------------------
// LPAL divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module lpal_divider (
  input  logic                clk,
  input  logic                rst,
  input  lpal_pkg::div_req_t  req,
  output lpal_pkg::div_rsp_t  rsp
);
  import lpal_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [MOD_W-1:0] rem;
  logic [MOD_W-1:0] dsr;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [MOD_W:0]   partial;
  logic [MOD_W+1:0] diff;

  assign partial = {rem, dvd[DVD_W-1]};
  assign diff    = {1'b0, partial} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!diff[MOD_W+1]) begin
        rem <= diff[MOD_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rem <= partial[MOD_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

// ===== sv/lpal_wave_interp.sv =====
// ----------------------------------------------------------------------------
// LPAL wave table and interpolator
// Waveform memory with two read ports and a three-stage linear interpolator.
// ----------------------------------------------------------------------------
module lpal_wave_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [lpal_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  lpal_pkg::interp_req_t       req,
  output logic                        done,
  output logic [7:0]                  sample
);
  import lpal_pkg::*;

  logic [7:0]          mem [TABLE_DEPTH];
  logic [7:0]          rd_a;
  logic [7:0]          rd_b;
  logic                v1;
  logic                v2;
  logic [15:0]         frac1;
  logic [FB_W-1:0]     fb1;
  logic [FB_W-1:0]     fb2;
  logic [7:0]          a2;
  logic signed [25:0]  prod;
  logic signed [8:0]   diff;
  logic signed [16:0]  frac_s;
  logic [26:0]         a_sh;
  logic [26:0]         total;
  logic [26:0]         shifted;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[req.idx];
    rd_b <= mem[req.nxt];
  end

  assign diff   = $signed({1'b0, rd_b}) - $signed({1'b0, rd_a});
  assign frac_s = $signed({1'b0, frac1});

  always_ff @(posedge clk) begin
    frac1 <= req.frac;
    fb1   <= req.fb;
    prod  <= diff * frac_s;
    a2    <= rd_a;
    fb2   <= fb1;
  end

  assign a_sh    = {19'b0, a2} << fb2;
  assign total   = a_sh + {prod[25], prod};
  assign shifted = total >> fb2;

  always_ff @(posedge clk) begin
    if (v2) begin
      sample <= shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.start;
      v2   <= v1;
      done <= v2;
    end
  end

endmodule

// ===== sv/lut_phase_accumulator_lerp_unit.sv =====
// ----------------------------------------------------------------------------
// Table-driven phase oscillator with linear interpolation
// Phase accumulator over a waveform memory; the increment is recomputed on
// every register write by a shared iterative divider.
// ----------------------------------------------------------------------------
// A tick passes through the reduce, split, interpolate and output states, and the
// next item is taken only once its result is registered; a tick after a loaded
// phase at or above the modulus also goes through the divider. Table writes and
// phase loads complete at their transfer. After a register write the input
// stalls while two divider passes rebuild the increment.
// Synchronous reset restores register defaults and a zero phase and increment;
// table entries are undefined until written.
module lut_phase_accumulator_lerp_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [1:0]                   kind,
  input  logic [7:0]                   table_addr,
  input  logic [7:0]                   table_value,
  input  logic [23:0]                  new_phase,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [7:0]                   sample,
  output logic [7:0]                   table_index,
  output logic [15:0]                  phase_fraction,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpal_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lpal_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REDUCE  = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SPLIT   = 4'd3;
  localparam logic [3:0] S_INTERP  = 4'd4;
  localparam logic [3:0] S_OUT     = 4'd5;
  localparam logic [3:0] S_CMUL    = 4'd6;
  localparam logic [3:0] S_CDIV1S  = 4'd7;
  localparam logic [3:0] S_CDIV1W  = 4'd8;
  localparam logic [3:0] S_CDIV2S  = 4'd9;
  localparam logic [3:0] S_CDIV2W  = 4'd10;
  localparam logic [3:0] S_CCHK    = 4'd11;

  cfg_t        cfg;
  logic        cfg_wr;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  interp_req_t ireq;
  logic        interp_done;
  logic [7:0]  interp_sample;

  logic [3:0]         state;
  logic               cfg_dirty;
  logic [PHASE_W-1:0] phase;
  logic               phase_ok;
  logic [INC_W-1:0]   increment;
  logic [PHASE_W-1:0] inc_red;
  logic [MOD_W-1:0]   sum;
  logic [INC_W-1:0]   prod;
  logic [7:0]         index_r;
  logic [15:0]        frac_r;
  logic               accept;

  logic [ADDR_W-1:0]  split_idx;
  logic [15:0]        split_frac;
  logic [16:0]        frac_mask;
  logic [SIZE_W-1:0]  idx_inc;
  logic [ADDR_W-1:0]  split_nxt;
  logic [MOD_W-1:0]   sum_sub;

  assign pready = 1'b1;

  lpal_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  lpal_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lpal_wave_interp u_wave (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && kind == KIND_WRITE),
    .wr_addr (table_addr),
    .wr_data (table_value),
    .req     (ireq),
    .done    (interp_done),
    .sample  (interp_sample)
  );

  assign item_ready = (state == S_IDLE) && !cfg_dirty && !cfg_wr && !(psel && pwrite);
  assign accept     = item_valid && item_ready;

  assign split_idx  = ADDR_W'(phase >> cfg.fb);
  assign frac_mask  = (17'h1 << cfg.fb) - 17'h1;
  assign split_frac = phase[15:0] & frac_mask[15:0];
  assign idx_inc    = {1'b0, split_idx} + SIZE_W'(1);
  assign split_nxt  = (idx_inc >= cfg.size) ? '0 : idx_inc[ADDR_W-1:0];
  assign sum_sub    = sum - cfg.modulus;

  always_comb begin
    ireq.start = (state == S_SPLIT);
    ireq.idx   = split_idx;
    ireq.nxt   = split_nxt;
    ireq.frac  = split_frac;
    ireq.fb    = cfg.fb;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {8'b0, sum};
    div_req.divisor  = cfg.modulus;
    case (state)
      S_REDUCE: begin
        div_req.start = !phase_ok;
      end
      S_CDIV1S: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod};
        div_req.divisor  = MOD_W'(cfg.rate);
      end
      S_CDIV2S: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, increment};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg_dirty <= 1'b0;
      phase     <= '0;
      phase_ok  <= 1'b1;
      increment <= '0;
      inc_red   <= '0;
    end else begin
      if (cfg_wr) begin
        cfg_dirty <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cfg_dirty && !cfg_wr) begin
            cfg_dirty <= 1'b0;
            state     <= S_CMUL;
          end else if (accept) begin
            case (kind)
              KIND_TICK: begin
                sum   <= {1'b0, phase} + {1'b0, inc_red};
                state <= S_REDUCE;
              end
              KIND_PHASE: begin
                phase    <= new_phase;
                phase_ok <= ({1'b0, new_phase} < cfg.modulus);
              end
              default: begin
              end
            endcase
          end
        end
        S_REDUCE: begin
          if (phase_ok) begin
            phase <= (sum >= cfg.modulus) ? sum_sub[PHASE_W-1:0] : sum[PHASE_W-1:0];
            state <= S_SPLIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            phase    <= div_rsp.rem[PHASE_W-1:0];
            phase_ok <= 1'b1;
            state    <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          index_r <= split_idx;
          frac_r  <= split_frac;
          state   <= S_INTERP;
        end
        S_INTERP: begin
          if (interp_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        S_CMUL: begin
          prod  <= INC_W'(({9'b0, cfg.freq} * {24'b0, cfg.size}) << cfg.fb);
          state <= S_CDIV1S;
        end
        S_CDIV1S: begin
          state <= S_CDIV1W;
        end
        S_CDIV1W: begin
          if (div_rsp.done) begin
            increment <= div_rsp.quot[INC_W-1:0] >> cfg.shift;
            state     <= S_CDIV2S;
          end
        end
        S_CDIV2S: begin
          state <= S_CDIV2W;
        end
        S_CDIV2W: begin
          if (div_rsp.done) begin
            inc_red <= div_rsp.rem[PHASE_W-1:0];
            state   <= S_CCHK;
          end
        end
        S_CCHK: begin
          phase_ok <= ({1'b0, phase} < cfg.modulus);
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || result_ready)) begin
      sample         <= interp_sample;
      table_index    <= index_r;
      phase_fraction <= frac_r;
    end
  end

endmodule
